/* rtl/a64dp_pkg.sv */
// Shared types, codes and the operand shifter for the AArch64 data-processing execute block.
// No dependencies; every other file in rtl/ uses this package by scoped names.
`default_nettype none

package a64dp_pkg;

   // Full and half datapath widths
   localparam int unsigned XLEN = 64;
   localparam int unsigned HALF = 32;

   // Request transfer payload
   typedef struct packed {
      logic [31:0] instruction;
      logic [63:0] first_value;
      logic [63:0] second_value;
      logic [63:0] addend_value;
   } req_type;

   // Response transfer payload
   typedef struct packed {
      logic [4:0]  dest_index;
      logic [63:0] result_value;
      logic        sets_flags;
      logic        negative;
      logic        zero;
      logic        carry_out;
      logic        overflow;
   } rsp_type;

   // Instruction group, from bits 28 and 24
   typedef enum logic [1:0] {
      GROUP_LOGIC  = 2'd0,
      GROUP_ADDSUB = 2'd1,
      GROUP_MUL    = 2'd2
   } group_type;

   // Shift kind, bits 23:22
   typedef enum logic [1:0] {
      SHIFT_LSL = 2'd0,
      SHIFT_LSR = 2'd1,
      SHIFT_ASR = 2'd2,
      SHIFT_ROR = 2'd3
   } shift_type;

   // Logical group opc codes
   localparam logic [1:0] OPC_AND  = 2'd0;
   localparam logic [1:0] OPC_ORR  = 2'd1;
   localparam logic [1:0] OPC_EOR  = 2'd2;
   localparam logic [1:0] OPC_ANDS = 2'd3;

   // Decoded, shifted operands and partial products between the two stages
   typedef struct packed {
      logic [4:0]      dest;
      logic            wide;
      group_type       group;
      logic [1:0]      opc;
      logic            invert;
      logic            mul_sub;
      logic [XLEN-1:0] first;
      logic [XLEN-1:0] operand;
      logic [XLEN-1:0] addend;
      logic [XLEN-1:0] prod_low;
      logic [HALF-1:0] cross_lh;
      logic [HALF-1:0] cross_hl;
   } stage_type;

   // Shift or rotate the second operand at 32 or 64 bits; amount wraps at the width
   function automatic logic [XLEN-1:0] shift_operand(shift_type kind, logic [XLEN-1:0] v,
                                                     logic [5:0] amt, logic wide);
      logic [5:0]        s;
      logic [HALF-1:0]   v32;
      logic [HALF-1:0]   r32;
      logic [XLEN-1:0]   r64;
      logic [2*XLEN-1:0] rot64;
      logic [2*HALF-1:0] rot32;
      s     = wide ? amt : {1'b0, amt[4:0]};
      v32   = v[HALF-1:0];
      rot64 = {v, v} >> s;
      rot32 = {v32, v32} >> s[4:0];
      case (kind)
         SHIFT_LSL: begin
            r64 = v << s;
            r32 = v32 << s[4:0];
         end
         SHIFT_LSR: begin
            r64 = v >> s;
            r32 = v32 >> s[4:0];
         end
         SHIFT_ASR: begin
            r64 = $unsigned($signed(v) >>> s);
            r32 = $unsigned($signed(v32) >>> s[4:0]);
         end
         default: begin
            r64 = rot64[XLEN-1:0];
            r32 = rot32[HALF-1:0];
         end
      endcase
      return wide ? r64 : {{HALF{1'b0}}, r32};
   endfunction

endpackage

`default_nettype wire

/* rtl/a64dp_operand.sv */
// First stage: decodes the instruction, shifts Rm and forms the multiply partial products.
// Depends on a64dp_pkg.
`default_nettype none

module a64dp_operand (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   input  wire a64dp_pkg::req_type   in_req,
   output logic                      out_valid,
   output a64dp_pkg::stage_type      out_stage
);

   logic                 valid_ff;
   logic                 valid_in;
   a64dp_pkg::stage_type stage_ff;
   a64dp_pkg::stage_type stage_in;

   logic [31:0] insn;
   logic        wide;
   logic [63:0] a_val;
   logic [63:0] b_val;
   logic [63:0] c_val;
   logic [63:0] prod_ll;
   logic [63:0] prod_lh;
   logic [63:0] prod_hl;

   // Operands masked to the operand width
   assign insn  = in_req.instruction;
   assign wide  = insn[31];
   assign a_val = wide ? in_req.first_value  : {32'b0, in_req.first_value[31:0]};
   assign b_val = wide ? in_req.second_value : {32'b0, in_req.second_value[31:0]};
   assign c_val = wide ? in_req.addend_value : {32'b0, in_req.addend_value[31:0]};

   // 32x32 partial products; only the low half of the cross terms matters
   assign prod_ll = a_val[31:0]  * b_val[31:0];
   assign prod_lh = a_val[31:0]  * b_val[63:32];
   assign prod_hl = a_val[63:32] * b_val[31:0];

   // Decode and shift
   always_comb begin
      stage_in.dest     = insn[4:0];
      stage_in.wide     = wide;
      stage_in.group    = insn[28] ? a64dp_pkg::GROUP_MUL
                        : (insn[24] ? a64dp_pkg::GROUP_ADDSUB : a64dp_pkg::GROUP_LOGIC);
      stage_in.opc      = insn[30:29];
      stage_in.invert   = insn[21];
      stage_in.mul_sub  = insn[15];
      stage_in.first    = a_val;
      stage_in.operand  = a64dp_pkg::shift_operand(a64dp_pkg::shift_type'(insn[23:22]),
                                                   b_val, insn[15:10], wide);
      stage_in.addend   = c_val;
      stage_in.prod_low = prod_ll;
      stage_in.cross_lh = prod_lh[31:0];
      stage_in.cross_hl = prod_hl[31:0];
   end

   assign valid_in = in_valid;

   // Stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
   end

   assign out_valid = valid_ff;
   assign out_stage = stage_ff;

endmodule

`default_nettype wire

/* rtl/a64dp_execute.sv */
// Second stage: add/subtract, logical op or multiply accumulate, flags, result register.
// Depends on a64dp_pkg.
`default_nettype none

module a64dp_execute (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   input  wire a64dp_pkg::stage_type in_stage,
   output logic                      out_valid,
   output a64dp_pkg::rsp_type        out_rsp
);

   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   a64dp_pkg::rsp_type  rsp_ff;
   a64dp_pkg::rsp_type  rsp_in;

   logic [63:0] mask;
   logic [31:0] cross_sum;
   logic [63:0] product;
   logic [63:0] mul_res;
   logic [63:0] add_opnd;
   logic [64:0] sum;
   logic [63:0] add_res;
   logic        add_carry;
   logic        add_ovf;
   logic [63:0] logic_opnd;
   logic [63:0] logic_res;
   logic [63:0] result;
   logic        res_msb;
   logic        first_msb;
   logic        opnd_msb;

   assign mask = in_stage.wide ? {64{1'b1}} : {32'b0, {32{1'b1}}};

   // Multiply-add: combine partial products, then accumulate
   assign cross_sum = in_stage.cross_lh + in_stage.cross_hl;
   assign product   = in_stage.prod_low + {cross_sum, 32'b0};
   assign mul_res   = in_stage.mul_sub ? (in_stage.addend - product)
                                       : (in_stage.addend + product);

   // Add/subtract: subtract is Rn + ~op2 + 1 at the operand width
   assign add_opnd  = (in_stage.opc[1] ? ~in_stage.operand : in_stage.operand) & mask;
   assign sum       = {1'b0, in_stage.first} + {1'b0, add_opnd} + {64'b0, in_stage.opc[1]};
   assign add_res   = sum[63:0];
   assign add_carry = in_stage.wide ? sum[64] : sum[32];
   assign first_msb = in_stage.wide ? in_stage.first[63] : in_stage.first[31];
   assign opnd_msb  = in_stage.wide ? add_opnd[63] : add_opnd[31];

   // Logical group
   assign logic_opnd = in_stage.invert ? (~in_stage.operand & mask) : in_stage.operand;
   always_comb begin
      case (in_stage.opc)
         a64dp_pkg::OPC_ORR: logic_res = in_stage.first | logic_opnd;
         a64dp_pkg::OPC_EOR: logic_res = in_stage.first ^ logic_opnd;
         default:            logic_res = in_stage.first & logic_opnd;
      endcase
   end

   // Result select, masked to the operand width
   always_comb begin
      unique case (in_stage.group)
         a64dp_pkg::GROUP_MUL:    result = mul_res & mask;
         a64dp_pkg::GROUP_ADDSUB: result = add_res & mask;
         default:                 result = logic_res & mask;
      endcase
   end

   assign res_msb = in_stage.wide ? result[63] : result[31];
   assign add_ovf = (first_msb == opnd_msb) && (res_msb != first_msb);

   // Flags and response
   always_comb begin
      rsp_in.dest_index   = in_stage.dest;
      rsp_in.result_value = result;
      rsp_in.sets_flags   = 1'b0;
      rsp_in.negative     = 1'b0;
      rsp_in.zero         = 1'b0;
      rsp_in.carry_out    = 1'b0;
      rsp_in.overflow     = 1'b0;
      if ((in_stage.group == a64dp_pkg::GROUP_ADDSUB) && in_stage.opc[0]) begin
         rsp_in.sets_flags = 1'b1;
         rsp_in.negative   = res_msb;
         rsp_in.zero       = (result == 64'b0);
         rsp_in.carry_out  = add_carry;
         rsp_in.overflow   = add_ovf;
      end else if ((in_stage.group == a64dp_pkg::GROUP_LOGIC) &&
                   (in_stage.opc == a64dp_pkg::OPC_ANDS)) begin
         rsp_in.sets_flags = 1'b1;
         rsp_in.negative   = res_msb;
         rsp_in.zero       = (result == 64'b0);
      end
   end

   assign rsp_valid_in = in_valid;

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign out_valid = rsp_valid_ff;
   assign out_rsp   = rsp_ff;

endmodule

`default_nettype wire

/* rtl/aarch64_reg_data_processing_alu_top.sv */
// Top level of the AArch64 data-processing (register) execute block.
// Depends on a64dp_pkg, a64dp_operand and a64dp_execute.
//
//   Channel   Ports                    Direction  Transfer
//   request   start, busy, req_payload in         start high and busy low at a clock edge
//   response  rsp_valid, rsp_payload   out        rsp_valid high for one cycle, no back-pressure
//
// One instruction is taken every cycle; busy stays low.
// A request taken at a clock edge passes through the input register and the operand/multiply
// stage, and is strobed on rsp_valid from the result register.
// The 64-bit multiply is split into three 32x32 products so the pipe depth is set
// by the multiplier stage. Synchronous reset clears all valid bits.
`default_nettype none

module aarch64_reg_data_processing_alu_top (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire a64dp_pkg::req_type   req_payload,
   output logic                      rsp_valid,
   output a64dp_pkg::rsp_type        rsp_payload
);

   logic                 req_valid_ff;
   logic                 req_valid_in;
   a64dp_pkg::req_type   req_ff;
   logic                 stage_valid;
   a64dp_pkg::stage_type stage;

   // Never stalls
   assign busy         = 1'b0;
   assign req_valid_in = start && !busy;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_payload;
   end

   a64dp_operand u_operand (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid_ff),
      .in_req    (req_ff),
      .out_valid (stage_valid),
      .out_stage (stage)
   );

   a64dp_execute u_execute (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (stage_valid),
      .in_stage  (stage),
      .out_valid (rsp_valid),
      .out_rsp   (rsp_payload)
   );

endmodule

`default_nettype wire
